// ===== rtl/lcm_pkg.sv =====
// Shared types, widths, constants and datapath helpers for the letterbox coordinate mapper.
package lcm_pkg;

  localparam int CRD_W   = 16;   // coordinate width
  localparam int DIM_W   = 14;   // window and viewport dimension width
  localparam int MAG_W   = 30;   // magnitude of the scaled numerator
  localparam int RES_W   = MAG_W + 2;
  localparam int CIDX_W  = 1;    // configuration register index width

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_WIN_WIDTH  = 1'b0;
  localparam logic [CIDX_W-1:0] REG_WIN_HEIGHT = 1'b1;

  // Derived viewport
  typedef struct packed {
    logic             ok;
    logic [DIM_W-1:0] left;
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } view_t;

  // One axis of an item in flight: numerator magnitude that turns into the quotient
  typedef struct packed {
    logic [MAG_W-1:0] acc;
    logic [DIM_W-1:0] rem;
    logic [DIM_W-1:0] dvs;
    logic             neg;
    logic [DIM_W-1:0] off;
  } axis_t;

  typedef struct packed {
    logic  ok;
    axis_t x;
    axis_t y;
  } op_t;

  // One restoring division step: shift in a numerator bit, subtract if it fits
  function automatic axis_t div_step(axis_t a);
    logic [DIM_W:0] part;
    axis_t          r;
    r    = a;
    part = {a.rem, a.acc[MAG_W-1]};
    r.acc = {a.acc[MAG_W-2:0], 1'b0};
    if (part >= {1'b0, a.dvs}) begin
      part     = part - {1'b0, a.dvs};
      r.acc[0] = 1'b1;
    end
    r.rem = part[DIM_W-1:0];
    return r;
  endfunction

  function automatic op_t op_step(op_t a);
    op_t r;
    r   = a;
    r.x = div_step(a.x);
    r.y = div_step(a.y);
    return r;
  endfunction

  // Apply sign and offset to the quotient, then saturate to 16-bit signed
  function automatic logic [CRD_W-1:0] axis_final(axis_t a);
    logic signed [RES_W-1:0] q;
    logic signed [RES_W-1:0] v;
    logic [CRD_W-1:0]        r;
    q = $signed({2'b00, a.acc});
    v = (a.neg ? -q : q) + $signed({{(RES_W-DIM_W){1'b0}}, a.off});
    if (v > $signed(RES_W'(32767))) begin
      r = 16'h7fff;
    end else if (v < -$signed(RES_W'(32768))) begin
      r = 16'h8000;
    end else begin
      r = v[CRD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/lcm_if.sv =====
// Valid/ready channel interfaces for points in and mapped points out.
interface lcm_in_if
  import lcm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             func;
  logic [CRD_W-1:0] coord_x;
  logic [CRD_W-1:0] coord_y;

  modport source (output valid, func, coord_x, coord_y, input ready);
  modport sink   (input valid, func, coord_x, coord_y, output ready);
endinterface

interface lcm_out_if
  import lcm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CRD_W-1:0] mapped_x;
  logic [CRD_W-1:0] mapped_y;
  logic             ok;

  modport source (output valid, mapped_x, mapped_y, ok, input ready);
  modport sink   (input valid, mapped_x, mapped_y, ok, output ready);
endinterface

// ===== rtl/lcm_viewport.sv =====
// Window size registers and the three-stage viewport derivation.
module lcm_viewport
  import lcm_pkg::*;
#(
  parameter int ASPECT_W = 4,
  parameter int ASPECT_H = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]  cfg_data,
  output view_t             view,
  output logic              busy
);

  localparam int AR_W = 7;
  localparam int NUM_W = DIM_W + AR_W;
  localparam int RS = 26;
  localparam longint RCP_W_L = ((64'(1) << RS) + ASPECT_W - 1) / ASPECT_W;
  localparam longint RCP_H_L = ((64'(1) << RS) + ASPECT_H - 1) / ASPECT_H;
  localparam logic [RS:0] RCP_W = RCP_W_L[RS:0];
  localparam logic [RS:0] RCP_H = RCP_H_L[RS:0];

  logic [DIM_W-1:0]    win_w_r, win_h_r;
  logic [1:0]          cnt_r;
  logic                wide_r;
  logic [NUM_W-1:0]    num_r;
  logic [NUM_W+RS:0]   prod_r;
  view_t               view_r;

  logic [NUM_W-1:0]    w_ah, h_aw;
  logic [DIM_W-1:0]    quo, vw, vh, bot;
  view_t               view_nxt;

  // Hold the window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_w_r <= DIM_W'(640);
      win_h_r <= DIM_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIN_WIDTH:  win_w_r <= cfg_data;
        REG_WIN_HEIGHT: win_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Count down while the derivation settles
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      cnt_r <= 2'd3;
    end else if (cnt_r != 2'd0) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end
  assign busy = (cnt_r != 2'd0);

  // Stage A: pick the full side
  assign w_ah = NUM_W'(win_w_r) * NUM_W'(ASPECT_H);
  assign h_aw = NUM_W'(win_h_r) * NUM_W'(ASPECT_W);
  always_ff @(posedge clk) begin
    wide_r <= (w_ah > h_aw);
    num_r  <= (w_ah > h_aw) ? h_aw : w_ah;
  end

  // Stage B: divide by the aspect term through its reciprocal
  always_ff @(posedge clk) begin
    prod_r <= (NUM_W+RS+1)'(num_r) * (NUM_W+RS+1)'(wide_r ? RCP_H : RCP_W);
  end

  // Stage C: clamp and center
  always_comb begin
    quo = prod_r[RS+DIM_W-1:RS];
    if (quo == '0) begin
      quo = DIM_W'(1);
    end
    vw  = wide_r ? quo : win_w_r;
    vh  = wide_r ? win_h_r : quo;
    bot = (win_h_r - vh) >> 1;
    if (win_w_r == '0 || win_h_r == '0) begin
      view_nxt.ok     = 1'b0;
      view_nxt.left   = '0;
      view_nxt.top    = '0;
      view_nxt.width  = DIM_W'(1);
      view_nxt.height = DIM_W'(1);
    end else begin
      view_nxt.ok     = 1'b1;
      view_nxt.left   = (win_w_r - vw) >> 1;
      view_nxt.top    = win_h_r - bot - vh;
      view_nxt.width  = vw;
      view_nxt.height = vh;
    end
  end

  always_ff @(posedge clk) begin
    view_r <= view_nxt;
  end
  assign view = view_r;

endmodule

// ===== rtl/lcm_front.sv =====
// Front end: accept a point, pick direction, form numerator and divisor per axis.
module lcm_front
  import lcm_pkg::*;
#(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 200
) (
  input  logic   clk,
  input  logic   rst_n,
  lcm_in_if.sink in_ch,
  input  view_t  view,
  input  logic   busy,
  input  logic   q_ready,
  output logic   push,
  output op_t    push_op
);

  localparam logic [DIM_W-1:0] FRM_W = DIM_W'(FRAME_WIDTH);
  localparam logic [DIM_W-1:0] FRM_H = DIM_W'(FRAME_HEIGHT);

  logic f_valid_r;
  op_t  f_op_r;
  op_t  op_nxt;
  logic f_en;

  // Scale setup for one axis: |c| * dst + src/2, sign of c, divisor src
  function automatic axis_t prep(logic dir, logic [CRD_W-1:0] crd, logic [DIM_W-1:0] voff,
                                 logic [DIM_W-1:0] vdim, logic [DIM_W-1:0] frm);
    logic signed [CRD_W:0] c;
    logic [CRD_W:0]        m;
    logic [DIM_W-1:0]      dst;
    axis_t                 r;
    c = $signed({crd[CRD_W-1], crd});
    if (dir) begin
      c = c - $signed({{(CRD_W+1-DIM_W){1'b0}}, voff});
    end
    m     = c[CRD_W] ? 17'(-c) : 17'(c);
    dst   = dir ? frm : vdim;
    r.dvs = dir ? vdim : frm;
    r.acc = MAG_W'(m[CRD_W-1:0]) * MAG_W'(dst) + MAG_W'(r.dvs >> 1);
    r.rem = '0;
    r.neg = c[CRD_W];
    r.off = dir ? '0 : voff;
    return r;
  endfunction

  always_comb begin
    op_nxt.ok = view.ok;
    op_nxt.x  = prep(in_ch.func, in_ch.coord_x, view.left, view.width, FRM_W);
    op_nxt.y  = prep(in_ch.func, in_ch.coord_y, view.top, view.height, FRM_H);
  end

  // Advance when the stage is empty or its item moves into the queue
  assign f_en        = !f_valid_r || q_ready;
  assign in_ch.ready = f_en && !busy;
  assign push        = f_valid_r && q_ready;
  assign push_op     = f_op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (f_en) begin
      f_valid_r <= in_ch.valid && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      f_op_r <= op_nxt;
    end
  end

endmodule

// ===== rtl/lcm_queue.sv =====
// Four-entry queue between the front end and the divider pipeline.
module lcm_queue
  import lcm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic q_ready,
  input  logic pop,
  output logic q_valid,
  output op_t  head
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  op_t              mem [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [PTR_W:0]   cnt_r;

  assign q_ready = (cnt_r != (PTR_W+1)'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign head    = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_op;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_r <= rd_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (PTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/lcm_back.sv =====
// Back end: pipelined restoring dividers for both axes, then sign, offset and saturation.
module lcm_back
  import lcm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  op_t        head,
  output logic       pop,
  lcm_out_if.source  out_ch
);

  localparam int NST = MAG_W;

  op_t              st_r [NST];
  logic [NST-1:0]   v_r;
  logic             en;
  logic             out_valid_r;
  logic [CRD_W-1:0] mx_r, my_r;
  logic             ok_r;

  // Stall the whole pipe while the result register is held
  assign en  = !out_valid_r || out_ch.ready;
  assign pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= op_step(head);
    end
  end

  for (genvar i = 1; i < NST; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[i] <= op_step(st_r[i-1]);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_r <= st_r[NST-1].ok;
      mx_r <= st_r[NST-1].ok ? axis_final(st_r[NST-1].x) : '0;
      my_r <= st_r[NST-1].ok ? axis_final(st_r[NST-1].y) : '0;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.mapped_x = mx_r;
  assign out_ch.mapped_y = my_r;
  assign out_ch.ok       = ok_r;

endmodule

// ===== rtl/letterbox_coordinate_mapper.sv =====
// Top level: viewport derivation, front end, queue and divider back end.
// Throughput: one item per cycle, unless the output stalls or a config write holds
// the input off; the 30-stage divider pipeline per axis sets the depth.
// A configuration write holds the input off while the viewport settles.
// Reset (synchronous, rst_n low) loads a 640 x 480 window, empties the pipe and
// holds the input off after release while the viewport settles.
module letterbox_coordinate_mapper
  import lcm_pkg::*;
#(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 200,
  parameter int ASPECT_W     = 4,
  parameter int ASPECT_H     = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]  cfg_data,
  lcm_in_if.sink            in_ch,
  lcm_out_if.source         out_ch
);

  view_t view;
  logic  busy;
  logic  push, q_ready, pop, q_valid;
  op_t   push_op, head;

  lcm_viewport #(
    .ASPECT_W (ASPECT_W),
    .ASPECT_H (ASPECT_H)
  ) u_view (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .view      (view),
    .busy      (busy)
  );

  lcm_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .view    (view),
    .busy    (busy),
    .q_ready (q_ready),
    .push    (push),
    .push_op (push_op)
  );

  lcm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .q_ready (q_ready),
    .pop     (pop),
    .q_valid (q_valid),
    .head    (head)
  );

  lcm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== test/lcm_checker.sv =====
// Checker for the letterbox coordinate mapper: predicts each mapped point and compares.
`timescale 1ns / 1ps
module lcm_checker
  import lcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]  cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_func,
  input  logic [CRD_W-1:0]  in_coord_x,
  input  logic [CRD_W-1:0]  in_coord_y,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [CRD_W-1:0]  out_mapped_x,
  input  logic [CRD_W-1:0]  out_mapped_y,
  input  logic              out_ok,
  output int                fail_count,
  output int                pending,
  output int                mapped_count
);

  localparam int FRAME_W = 320;
  localparam int FRAME_H = 200;
  localparam int ASP_W   = 4;
  localparam int ASP_H   = 3;

  typedef struct packed {
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic             ok;
  } point_t;

  logic [DIM_W-1:0] win_w, win_h;
  longint vleft, vtop, vwidth, vheight;
  bit     size_ok;
  point_t expected_points[$];

  // Recompute the viewport from the window size
  function automatic void derive_view();
    longint w, h, vw, vh, bot;
    w = win_w;
    h = win_h;
    if (w < 1 || h < 1) begin
      size_ok = 0; vleft = 0; vtop = 0; vwidth = 1; vheight = 1;
      return;
    end
    size_ok = 1;
    if (w * ASP_H > h * ASP_W) begin
      vh = h; vw = h * ASP_W / ASP_H;
    end else begin
      vw = w; vh = w * ASP_H / ASP_W;
    end
    if (vw < 1) vw = 1;
    if (vh < 1) vh = 1;
    vwidth = vw;
    vheight = vh;
    vleft = (w - vw) / 2;
    bot = (h - vh) / 2;
    vtop = h - bot - vh;
  endfunction

  function automatic longint scale_coord(longint c, longint src, longint dst);
    longint n;
    n = c * dst;
    n = (n < 0) ? n - src / 2 : n + src / 2;
    return n / src;
  endfunction

  function automatic logic [CRD_W-1:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[CRD_W-1:0];
  endfunction

  function automatic point_t map_point(logic f, logic [CRD_W-1:0] cx, logic [CRD_W-1:0] cy);
    point_t p;
    longint sx, sy;
    sx = longint'($signed(cx));
    sy = longint'($signed(cy));
    if (!size_ok) return '0;
    if (f == 1'b0) begin
      p.x = clamp16(vleft + scale_coord(sx, FRAME_W, vwidth));
      p.y = clamp16(vtop + scale_coord(sy, FRAME_H, vheight));
    end else begin
      p.x = clamp16(scale_coord(sx - vleft, vwidth, FRAME_W));
      p.y = clamp16(scale_coord(sy - vtop, vheight, FRAME_H));
    end
    p.ok = 1'b1;
    return p;
  endfunction

  always @(posedge clk) begin
    point_t got, want;
    if (!rst_n) begin
      win_w = 640;
      win_h = 480;
      derive_view();
      expected_points.delete();
      fail_count <= 0;
      mapped_count <= 0;
      pending <= 0;
    end else begin
      // Track register writes
      if (cfg_we) begin
        if (cfg_index == REG_WIN_WIDTH) win_w = cfg_data;
        else if (cfg_index == REG_WIN_HEIGHT) win_h = cfg_data;
        derive_view();
      end
      // Predict each accepted item
      if (in_valid && in_ready)
        expected_points.push_back(map_point(in_func, in_coord_x, in_coord_y));
      // Compare each delivered result
      if (out_valid && out_ready) begin
        got = '{out_mapped_x, out_mapped_y, out_ok};
        mapped_count <= mapped_count + 1;
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d ok=%0b", $time,
                   $signed(got.x), $signed(got.y), got.ok);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_points.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected x=%0d y=%0d ok=%0b actual x=%0d y=%0d ok=%0b",
                     $time, $signed(want.x), $signed(want.y), want.ok,
                     $signed(got.x), $signed(got.y), got.ok);
            fail_count <= fail_count + 1;
          end
        end
      end
      // Publish the number of items still owed
      pending <= expected_points.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// Stimulus top for the letterbox coordinate mapper: items, window sizes, idling, verdict.
`timescale 1ns / 1ps
module testbench;
  import lcm_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]  cfg_data;
  int                fail_count, pending, mapped_count;
  int                send_idle_pct, recv_stall_pct;
  bit                hold_off;
  int                hold_cycles;

  lcm_in_if  in_ch();
  lcm_out_if out_ch();

  letterbox_coordinate_mapper uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  lcm_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_func(in_ch.func),
    .in_coord_x(in_ch.coord_x), .in_coord_y(in_ch.coord_y),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_mapped_x(out_ch.mapped_x),
    .out_mapped_y(out_ch.mapped_y), .out_ok(out_ch.ok),
    .fail_count(fail_count), .pending(pending), .mapped_count(mapped_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random, or hold it off entirely
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Count the long hold-off in its own process
  initial begin
    hold_off = 0;
    wait (hold_cycles > 0);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (hold_cycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Offer one item after optional idle cycles; wait for acceptance
  task automatic send_point(logic f, logic [CRD_W-1:0] x, logic [CRD_W-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= f;
    in_ch.coord_x <= x;
    in_ch.coord_y <= y;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop the input, let results drain, then write a window size
  task automatic set_window(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= REG_WIN_WIDTH; cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_WIN_HEIGHT; cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_points(int n);
    int k;
    logic [CRD_W-1:0] x, y;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0: begin x = CRD_W'($urandom); y = CRD_W'($urandom); end
        1: begin x = CRD_W'($urandom_range(400)); y = CRD_W'($urandom_range(260)); end
        2: begin x = CRD_W'($urandom_range(2000)); y = CRD_W'($urandom_range(2000)); end
        default: begin
          x = CRD_W'(-$urandom_range(500));
          y = CRD_W'(-$urandom_range(500));
        end
      endcase
      send_point(1'($urandom_range(1)), x, y);
    end
  endtask

  logic [DIM_W-1:0] sizes_w[8] = '{640, 16383, 0, 1, 800, 3, 16383, 1000};
  logic [DIM_W-1:0] sizes_h[8] = '{480, 16383, 50, 1, 600, 0, 1, 2};
  int idle_s[4] = '{0, 49, 0, 13};
  int idle_r[4] = '{0, 0, 49, 13};

  initial begin
    int p, wd;
    rst_n = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    in_ch.valid = 0; in_ch.func = 0; in_ch.coord_x = '0; in_ch.coord_y = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: field extremes in both directions at the reset window
    send_point(0, 16'h0000, 16'h0000);
    send_point(0, 16'd319, 16'd199);
    send_point(0, 16'h7fff, 16'h7fff);
    send_point(0, 16'h8000, 16'h8000);
    send_point(0, 16'hffff, 16'hffff);
    send_point(1, 16'd80, 16'd0);
    send_point(1, 16'd719, 16'd479);
    send_point(1, 16'h7fff, 16'h8000);
    send_point(1, 16'h8000, 16'h7fff);
    send_point(1, 16'hffff, 16'h0001);
    send_point(1, 16'h5555, 16'haaaa);
    // Long receiver hold-off while items keep coming
    hold_cycles = 300;
    random_points(100);
    // Extreme and empty windows
    set_window(16383, 16383);
    send_point(0, 16'h7fff, 16'h8000);
    send_point(1, 16'h8000, 16'h7fff);
    set_window(0, 480);
    send_point(0, 16'd5, 16'd5);
    send_point(1, 16'h7fff, 16'h7fff);
    // Random phases across window sizes and idling mixes
    for (p = 0; p < 4; p++) begin
      send_idle_pct = idle_s[p];
      recv_stall_pct = idle_r[p];
      for (wd = 0; wd < 8; wd++) begin
        set_window(sizes_w[wd], sizes_h[wd]);
        random_points(38);
      end
    end
    set_window(DIM_W'($urandom), DIM_W'($urandom));
    random_points(20);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Mapped %0d points both ways over extreme, empty and random window sizes,",
             mapped_count);
    $display("with sender gaps, receiver stalls and a long output hold-off.");
    if (fail_count == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// ===== letterbox_coordinate_mapper.f =====
rtl/lcm_pkg.sv
rtl/lcm_if.sv
rtl/lcm_viewport.sv
rtl/lcm_front.sv
rtl/lcm_queue.sv
rtl/lcm_back.sv
rtl/letterbox_coordinate_mapper.sv
test/lcm_checker.sv
test/testbench.sv
